>>> rtl/core/speed_pi_controller_decimated_defines.svh
// Assertion macros for the speed PI controller.
// Included by files that carry concurrent checks; expects clk and rst in scope.
`ifndef SPEED_PI_CONTROLLER_DECIMATED_DEFINES_SVH
`define SPEED_PI_CONTROLLER_DECIMATED_DEFINES_SVH

`ifndef SYNTHESIS
`define SPCD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spcd assertion failed");
`define SPCD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spcd assertion failed");
`else
`define SPCD_ASSERT_IMP(name, ante, cons)
`define SPCD_ASSERT_NXT(name, ante, cons)
`endif

`endif

>>> rtl/core/spcd_pkg.sv
// Shared types and constants for the speed PI controller.
// No dependencies; used by every other file of the block but the macro header.
package spcd_pkg;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_MAX = 32'sh7FFF_FFFF;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef logic [2:0] alu_op_t;
  localparam alu_op_t OP_MUL   = 3'd0;
  localparam alu_op_t OP_ADD   = 3'd1;
  localparam alu_op_t OP_SUB   = 3'd2;
  localparam alu_op_t OP_ABS   = 3'd3;
  localparam alu_op_t OP_CLAMP = 3'd4;

  typedef struct packed {
    alu_op_t op;
    q_t      a;
    q_t      b;
  } alu_req_t;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_RATED_SPEED   = 3'd0;
  localparam reg_idx_t REG_PROP_GAIN     = 3'd1;
  localparam reg_idx_t REG_INTEG_GAIN    = 3'd2;
  localparam reg_idx_t REG_DAMPING_GAIN  = 3'd3;
  localparam reg_idx_t REG_INV_POLE      = 3'd4;
  localparam reg_idx_t REG_CURRENT_OFS   = 3'd5;
  localparam reg_idx_t REG_PERIOD_TICKS  = 3'd6;
  localparam reg_idx_t REG_TICK_TIME     = 3'd7;

  typedef struct packed {
    logic [30:0] rated_speed;
    logic [30:0] prop_gain;
    logic [30:0] integ_gain;
    logic [30:0] damping_gain;
    logic [30:0] inv_pole_pairs;
    logic [30:0] current_limit_offset;
    logic [15:0] period_ticks;
    logic [30:0] tick_time;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic at_output;
    q_t   integ;
    q_t   limit;
  } core_stat_t;

endpackage

>>> rtl/core/spcd_if.sv
// Valid/ready channel interfaces for the speed PI controller.
// Depends on spcd_pkg for the Q16.16 type.
interface spcd_tick_if;
  logic           valid;
  logic           ready;
  spcd_pkg::q_t   speed_command;
  spcd_pkg::q_t   measured_speed;
  logic           integrator_hold;

  modport source(output valid, speed_command, measured_speed, integrator_hold,
                 input ready);
  modport sink(input valid, speed_command, measured_speed, integrator_hold,
               output ready);
endinterface

interface spcd_result_if;
  logic           valid;
  logic           ready;
  spcd_pkg::q_t   q_current_ref;

  modport source(output valid, q_current_ref, input ready);
  modport sink(input valid, q_current_ref, output ready);
endinterface

>>> rtl/core/spcd_cfg.sv
// APB register bank for the speed PI controller settings.
// Depends on spcd_pkg (cfg_t, register indexes).
module spcd_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output spcd_pkg::cfg_t     cfg
);

  spcd_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx   = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rated_speed          <= 31'd65536;
      cfg.prop_gain            <= 31'd65536;
      cfg.integ_gain           <= 31'd0;
      cfg.damping_gain         <= 31'd65536;
      cfg.inv_pole_pairs       <= 31'd32768;
      cfg.current_limit_offset <= 31'd65536;
      cfg.period_ticks         <= 16'd1;
      cfg.tick_time            <= 31'd7;
    end else if (wr_en) begin
      unique case (idx)
        spcd_pkg::REG_RATED_SPEED:  cfg.rated_speed          <= pwdata[30:0];
        spcd_pkg::REG_PROP_GAIN:    cfg.prop_gain            <= pwdata[30:0];
        spcd_pkg::REG_INTEG_GAIN:   cfg.integ_gain           <= pwdata[30:0];
        spcd_pkg::REG_DAMPING_GAIN: cfg.damping_gain         <= pwdata[30:0];
        spcd_pkg::REG_INV_POLE:     cfg.inv_pole_pairs       <= pwdata[30:0];
        spcd_pkg::REG_CURRENT_OFS:  cfg.current_limit_offset <= pwdata[30:0];
        spcd_pkg::REG_PERIOD_TICKS: cfg.period_ticks         <= pwdata[15:0];
        spcd_pkg::REG_TICK_TIME:    cfg.tick_time            <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      spcd_pkg::REG_RATED_SPEED:  prdata = {1'b0, cfg.rated_speed};
      spcd_pkg::REG_PROP_GAIN:    prdata = {1'b0, cfg.prop_gain};
      spcd_pkg::REG_INTEG_GAIN:   prdata = {1'b0, cfg.integ_gain};
      spcd_pkg::REG_DAMPING_GAIN: prdata = {1'b0, cfg.damping_gain};
      spcd_pkg::REG_INV_POLE:     prdata = {1'b0, cfg.inv_pole_pairs};
      spcd_pkg::REG_CURRENT_OFS:  prdata = {1'b0, cfg.current_limit_offset};
      spcd_pkg::REG_PERIOD_TICKS: prdata = {16'd0, cfg.period_ticks};
      spcd_pkg::REG_TICK_TIME:    prdata = {1'b0, cfg.tick_time};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

>>> rtl/core/spcd_alu.sv
// Shared saturating Q16.16 arithmetic unit: multiply, add, subtract,
// absolute value and symmetric clamp. Depends on spcd_pkg.
module spcd_alu (
  input  spcd_pkg::alu_req_t req,
  output spcd_pkg::q_t       y
);

  function automatic spcd_pkg::q_t sat48(input logic signed [47:0] v);
    if (v[47:31] == {17{v[47]}})
      return v[31:0];
    else
      return v[47] ? spcd_pkg::Q_MIN : spcd_pkg::Q_MAX;
  endfunction

  function automatic spcd_pkg::q_t sat33(input logic signed [32:0] v);
    if (v[32] == v[31])
      return v[31:0];
    else
      return v[32] ? spcd_pkg::Q_MIN : spcd_pkg::Q_MAX;
  endfunction

  logic signed [63:0] prod;
  logic signed [32:0] a_x;
  logic signed [32:0] b_x;
  spcd_pkg::q_t       neg_b;

  assign a_x   = {req.a[31], req.a};
  assign b_x   = {req.b[31], req.b};
  // b is a non-negative limit in the clamp, so its negation fits
  assign neg_b = -req.b;
  assign prod  = $signed({{32{req.a[31]}}, req.a}) * $signed({{32{req.b[31]}}, req.b});

  always_comb begin
    unique case (req.op)
      // dropping 16 low bits of a two's complement product rounds toward -inf
      spcd_pkg::OP_MUL:   y = sat48(prod[63:16]);
      spcd_pkg::OP_ADD:   y = sat33(a_x + b_x);
      spcd_pkg::OP_SUB:   y = sat33(a_x - b_x);
      spcd_pkg::OP_ABS:   y = sat33(req.a[31] ? (33'sd0 - a_x) : a_x);
      spcd_pkg::OP_CLAMP: begin
        if (req.a > req.b)
          y = req.b;
        else if (req.a < neg_b)
          y = neg_b;
        else
          y = req.a;
      end
      default:            y = req.a;
    endcase
  end

endmodule

>>> rtl/core/spcd_core.sv
// Sequencer and state registers of the speed PI controller: walks one tick
// through the shared ALU step by step. Depends on spcd_pkg.
module spcd_core (
  input  logic                   clk,
  input  logic                   rst,
  input  spcd_pkg::cfg_t         cfg,
  input  logic                   tick_valid,
  output logic                   tick_ready,
  input  spcd_pkg::q_t           speed_command,
  input  spcd_pkg::q_t           measured_speed,
  input  logic                   integrator_hold,
  output logic                   res_valid,
  input  logic                   res_ready,
  output spcd_pkg::q_t           res_data,
  output spcd_pkg::alu_req_t     alu_req,
  input  spcd_pkg::q_t           alu_y,
  output spcd_pkg::core_stat_t   stat
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_REF   = 5'd1;
  localparam logic [4:0] ST_TIME  = 5'd2;
  localparam logic [4:0] ST_CHECK = 5'd3;
  localparam logic [4:0] ST_I1    = 5'd4;
  localparam logic [4:0] ST_I2    = 5'd5;
  localparam logic [4:0] ST_I3    = 5'd6;
  localparam logic [4:0] ST_INTEG = 5'd7;
  localparam logic [4:0] ST_P1    = 5'd8;
  localparam logic [4:0] ST_P2    = 5'd9;
  localparam logic [4:0] ST_L1    = 5'd10;
  localparam logic [4:0] ST_L2    = 5'd11;
  localparam logic [4:0] ST_L3    = 5'd12;
  localparam logic [4:0] ST_L4    = 5'd13;
  localparam logic [4:0] ST_CLAMP = 5'd14;
  localparam logic [4:0] ST_O1    = 5'd15;
  localparam logic [4:0] ST_O2    = 5'd16;
  localparam logic [4:0] ST_OUT   = 5'd17;

  logic [4:0]   state;
  logic [4:0]   state_next;
  spcd_pkg::q_t cmd;
  spcd_pkg::q_t spd;
  logic         hold;
  spcd_pkg::q_t ref_speed;
  spcd_pkg::q_t tmp;
  spcd_pkg::q_t prop;
  spcd_pkg::q_t limit;
  spcd_pkg::q_t integ;
  spcd_pkg::q_t elapsed;
  logic [15:0]  count;
  logic         out_fire;
  logic         is_update;

  spcd_pkg::q_t rated_q, kp_q, ki_q, damp_q, ipp_q, ofs_q, dt_q;

  assign rated_q = {1'b0, cfg.rated_speed};
  assign kp_q    = {1'b0, cfg.prop_gain};
  assign ki_q    = {1'b0, cfg.integ_gain};
  assign damp_q  = {1'b0, cfg.damping_gain};
  assign ipp_q   = {1'b0, cfg.inv_pole_pairs};
  assign ofs_q   = {1'b0, cfg.current_limit_offset};
  assign dt_q    = {1'b0, cfg.tick_time};

  assign tick_ready = (state == ST_IDLE);
  assign out_fire   = (state == ST_OUT) && (!res_valid || res_ready);
  assign is_update  = (count >= cfg.period_ticks);

  assign stat.busy      = (state != ST_IDLE);
  assign stat.at_output = (state == ST_OUT);
  assign stat.integ     = integ;
  assign stat.limit     = limit;

  // operand routing for the shared unit
  always_comb begin
    alu_req.op = spcd_pkg::OP_MUL;
    alu_req.a  = tmp;
    alu_req.b  = ipp_q;
    unique case (state)
      ST_REF:   begin alu_req.a = rated_q; alu_req.b = cmd; end
      ST_TIME:  begin alu_req.op = spcd_pkg::OP_ADD; alu_req.a = elapsed; alu_req.b = dt_q; end
      ST_CHECK: begin alu_req.op = spcd_pkg::OP_SUB; alu_req.a = ref_speed; alu_req.b = spd; end
      ST_I1:    begin alu_req.a = ki_q; alu_req.b = tmp; end
      ST_I2:    ;
      ST_I3:    alu_req.b = elapsed;
      ST_INTEG: begin alu_req.op = spcd_pkg::OP_ADD; alu_req.a = integ; alu_req.b = tmp; end
      ST_P1:    begin alu_req.a = damp_q; alu_req.b = ref_speed; end
      ST_P2:    begin alu_req.op = spcd_pkg::OP_SUB; alu_req.a = tmp; alu_req.b = spd; end
      ST_L1:    begin alu_req.op = spcd_pkg::OP_ABS; alu_req.a = prop; end
      ST_L2:    begin alu_req.a = kp_q; alu_req.b = tmp; end
      ST_L3:    ;
      ST_L4:    begin alu_req.op = spcd_pkg::OP_ADD; alu_req.b = ofs_q; end
      ST_CLAMP: begin alu_req.op = spcd_pkg::OP_CLAMP; alu_req.a = integ; alu_req.b = limit; end
      ST_O1:    begin alu_req.a = kp_q; alu_req.b = prop; end
      ST_O2:    ;
      ST_OUT:   begin alu_req.op = spcd_pkg::OP_ADD; alu_req.b = integ; end
      default:  ;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (tick_valid) state_next = ST_REF;
      ST_CHECK: state_next = is_update ? ST_I1 : ST_IDLE;
      ST_OUT:   if (out_fire) state_next = ST_IDLE;
      default:  state_next = state + 5'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
      integ     <= '0;
      elapsed   <= '0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready)
        res_valid <= 1'b0;
      if (out_fire)
        res_valid <= 1'b1;
      unique case (state) inside
        ST_TIME: begin
          elapsed <= alu_y;
          if (count != 16'hFFFF)
            count <= count + 16'd1;
        end
        ST_INTEG, ST_CLAMP: integ <= alu_y;
        ST_OUT: begin
          if (out_fire) begin
            if (hold)
              integ <= '0;
            elapsed <= '0;
            count   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath words, no reset needed
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && tick_valid) begin
      cmd  <= speed_command;
      spd  <= measured_speed;
      hold <= integrator_hold;
    end
    unique case (state) inside
      ST_REF:                          ref_speed <= alu_y;
      ST_CHECK, ST_I1, ST_I2, ST_I3,
      ST_P1, ST_L1, ST_L2, ST_L3,
      ST_O1, ST_O2:                    tmp <= alu_y;
      ST_P2:                           prop <= alu_y;
      ST_L4:                           limit <= alu_y;
      ST_OUT:                          if (out_fire) res_data <= alu_y;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/speed_pi_controller_decimated.sv
// Decimated motor speed PI regulator with anti-windup clamp.
// Channels: tick (sink) carries one control tick per word: speed_command,
// measured_speed, integrator_hold. result (source) carries q_current_ref,
// one word per control period. Settings are written over the APB port at
// byte address 4*index; the user is to write them only while the block is
// idle, which the block itself does not enforce; reads return the register.
// A tick that does not close a period keeps the block busy through REF, TIME
// and CHECK and yields nothing. A tick that closes a period walks the whole
// sequence; its result word is presented, and ready returns, in the same
// cycle. The sequence runs on the single shared multiply/add unit, used once
// per step. Ticks are taken one at a time; ready stays low while a tick is
// in work.
// The result sits in an output register: if the receiver stalls, the next
// tick is still taken, and only a second result waits at its last step.
// Reset (rst, synchronous) restores the settings registers to their defaults
// and clears the tick counter, elapsed time and integrator.
// Depends on spcd_pkg, spcd_if, spcd_cfg, spcd_alu, spcd_core.
`include "speed_pi_controller_decimated_defines.svh"

module speed_pi_controller_decimated (
  input  logic                 clk,
  input  logic                 rst,
  spcd_tick_if.sink            tick,
  spcd_result_if.source        result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  spcd_pkg::cfg_t       cfg;
  spcd_pkg::alu_req_t   alu_req;
  spcd_pkg::q_t         alu_y;
  spcd_pkg::core_stat_t stat;

  assign pready = 1'b1;

  spcd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  spcd_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  spcd_core u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .tick_valid      (tick.valid),
    .tick_ready      (tick.ready),
    .speed_command   (tick.speed_command),
    .measured_speed  (tick.measured_speed),
    .integrator_hold (tick.integrator_hold),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_data        (result.q_current_ref),
    .alu_req         (alu_req),
    .alu_y           (alu_y),
    .stat            (stat)
  );

  `SPCD_ASSERT_NXT(a_accept_starts_seq, tick.valid && tick.ready, stat.busy)
  `SPCD_ASSERT_IMP(a_result_from_seq, $rose(result.valid), $past(stat.at_output))
  `SPCD_ASSERT_IMP(a_integ_in_limit, stat.at_output, (stat.integ <= stat.limit) && (stat.integ >= -stat.limit))

endmodule
